// ----- rtl/dac_pkg.sv -----
package dac_pkg;

    // Word and slice geometry
    localparam int unsigned DAC_W   = 64;
    localparam int unsigned NIB_W   = 4;
    localparam int unsigned N_SLICE = DAC_W / NIB_W;

    // Radix constants of the code
    localparam logic [NIB_W-1:0] K_ONE      = 4'd1;
    localparam logic [NIB_W-1:0] K_NINE     = 4'd9;
    localparam logic [NIB_W-1:0] K_TEN      = 4'd10;
    localparam logic [NIB_W-1:0] EXP_MAX    = 4'd9;
    localparam logic [NIB_W-1:0] LAST_STRIP = 4'd8;

    typedef enum logic [3:0] {
        S_IDLE,
        S_STRIP,
        S_DIGIT,
        S_PACK9,
        S_PACK10,
        S_SPLIT10,
        S_SPLIT9,
        S_REBUILD,
        S_SCALE,
        S_OUT
    } t_state;

    // Sequencer to slice row
    typedef struct packed {
        logic             load;
        logic [DAC_W-1:0] load_val;
        logic             start;
        logic             div;
        logic [NIB_W-1:0] k;
        logic [NIB_W-1:0] cin;
    } t_row_ctl;

    // Slice row to sequencer
    typedef struct packed {
        logic             done;
        logic [NIB_W-1:0] cry;
        logic [DAC_W-1:0] val;
    } t_row_sts;

    // Divide a value below 16*den by den; returns {quotient, remainder}
    function automatic logic [2*NIB_W-1:0] div_small(input logic [2*NIB_W-1:0] num,
                                                      input logic [NIB_W-1:0]   den);
        logic [2*NIB_W-1:0] rem;
        logic [2*NIB_W-1:0] sub;
        logic [NIB_W-1:0]   quo;
        rem = num;
        quo = '0;
        for (int j = NIB_W - 1; j >= 0; j--) begin
            sub = {{NIB_W{1'b0}}, den} << j;
            if (rem >= sub) begin
                rem    = rem - sub;
                quo[j] = 1'b1;
            end
        end
        return {quo, rem[NIB_W-1:0]};
    endfunction

endpackage

// ----- rtl/decimal_amount_compressor.sv -----
// Converts a 64-bit amount to its compact decimal code (command 0) or back
// (command 1), one result per request, with an overflow flag when the exact
// value does not fit in 64 bits and the result has wrapped. The value sits in
// a row of 16 four-bit slices; every multiply by 9, 10 or 1 and every divide by
// 9 or 10 is a carry or remainder wave that runs through the row one slice per
// cycle. A zero request runs no pass. Compress makes e+1 strip passes for an
// amount with e < 9 trailing decimal zeros, then digit, multiply by 9 and by 10
// passes; with nine or more it strips nine zeros, then multiplies by 10.
// Decompress splits off the exponent e (divide by 10) and the digit (divide by
// 9, unless e = 9), rebuilds the value and multiplies it by 10 e times. One
// request is in flight at a time; the input stalls while it is worked on, and a
// finished result waits in the output register while the next request enters.
module decimal_amount_compressor (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic                      i_command,
    input  logic [dac_pkg::DAC_W-1:0] i_value,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [dac_pkg::DAC_W-1:0] o_result,
    output logic                      o_overflow
);

    localparam int unsigned W = dac_pkg::NIB_W;

    dac_pkg::t_state   r_state, n_state;
    dac_pkg::t_row_ctl ctl;
    dac_pkg::t_row_sts sts;

    logic                      r_go, n_go;
    logic [W-1:0]              r_e, n_e;
    logic [W-1:0]              r_dig, n_dig;
    logic [dac_pkg::DAC_W-1:0] r_save, n_save;
    logic                      r_ovf, n_ovf;
    logic                      r_ovalid;
    logic [dac_pkg::DAC_W-1:0] r_res;
    logic                      r_oovf;
    logic                      acc;
    logic                      out_free;
    logic                      cry_nz;

    assign acc      = i_valid && (r_state == dac_pkg::S_IDLE);
    assign out_free = !r_ovalid || !i_stall;
    assign cry_nz   = (sts.cry != '0);

    dac_row u_row (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .o_sts   (sts)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dac_pkg::S_IDLE: begin
                if (i_valid) begin
                    if (i_value == '0) begin
                        n_state = dac_pkg::S_OUT;
                    end else if (i_command) begin
                        n_state = dac_pkg::S_SPLIT10;
                    end else begin
                        n_state = dac_pkg::S_STRIP;
                    end
                end
            end
            dac_pkg::S_STRIP: begin
                if (sts.done) begin
                    if (cry_nz) begin
                        n_state = dac_pkg::S_DIGIT;
                    end else if (r_e == dac_pkg::LAST_STRIP) begin
                        n_state = dac_pkg::S_PACK10;
                    end else begin
                        n_state = dac_pkg::S_STRIP;
                    end
                end
            end
            dac_pkg::S_DIGIT: begin
                if (sts.done) begin
                    n_state = dac_pkg::S_PACK9;
                end
            end
            dac_pkg::S_PACK9: begin
                if (sts.done) begin
                    n_state = dac_pkg::S_PACK10;
                end
            end
            dac_pkg::S_PACK10: begin
                if (sts.done) begin
                    n_state = dac_pkg::S_OUT;
                end
            end
            dac_pkg::S_SPLIT10: begin
                if (sts.done) begin
                    if (sts.cry == dac_pkg::EXP_MAX) begin
                        n_state = dac_pkg::S_REBUILD;
                    end else begin
                        n_state = dac_pkg::S_SPLIT9;
                    end
                end
            end
            dac_pkg::S_SPLIT9: begin
                if (sts.done) begin
                    n_state = dac_pkg::S_REBUILD;
                end
            end
            dac_pkg::S_REBUILD: begin
                if (sts.done) begin
                    if (r_e == '0) begin
                        n_state = dac_pkg::S_OUT;
                    end else begin
                        n_state = dac_pkg::S_SCALE;
                    end
                end
            end
            dac_pkg::S_SCALE: begin
                if (sts.done && (r_e == dac_pkg::K_ONE)) begin
                    n_state = dac_pkg::S_OUT;
                end
            end
            dac_pkg::S_OUT: begin
                if (out_free) begin
                    n_state = dac_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = dac_pkg::S_IDLE;
            end
        endcase
    end

    // Row control and working registers
    always_comb begin
        n_e          = r_e;
        n_dig        = r_dig;
        n_save       = r_save;
        n_ovf        = r_ovf;
        ctl.load     = 1'b0;
        ctl.load_val = r_save;
        ctl.start    = r_go;
        ctl.div      = 1'b0;
        ctl.k        = dac_pkg::K_TEN;
        ctl.cin      = '0;

        // Select the pass for the current step
        unique case (r_state) inside
            dac_pkg::S_STRIP, dac_pkg::S_DIGIT, dac_pkg::S_SPLIT10: begin
                ctl.div = 1'b1;
                ctl.k   = dac_pkg::K_TEN;
            end
            dac_pkg::S_SPLIT9: begin
                ctl.div = 1'b1;
                ctl.k   = dac_pkg::K_NINE;
            end
            dac_pkg::S_PACK9: begin
                ctl.k   = dac_pkg::K_NINE;
                ctl.cin = W'(r_dig - dac_pkg::K_ONE);
            end
            dac_pkg::S_PACK10: begin
                ctl.k   = dac_pkg::K_TEN;
                ctl.cin = (r_e == dac_pkg::EXP_MAX) ? '0 : W'(r_e + dac_pkg::K_ONE);
            end
            dac_pkg::S_REBUILD: begin
                ctl.k   = (r_e == dac_pkg::EXP_MAX) ? dac_pkg::K_ONE : dac_pkg::K_TEN;
                ctl.cin = (r_e == dac_pkg::EXP_MAX) ? dac_pkg::K_ONE : r_dig;
            end
            default: begin
                ctl.k   = dac_pkg::K_TEN;
            end
        endcase

        // Capture what each pass leaves behind
        unique case (r_state) inside
            dac_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_e          = '0;
                    n_ovf        = 1'b0;
                    n_save       = i_value;
                    ctl.load     = 1'b1;
                    ctl.load_val = (i_command && (i_value != '0))
                                 ? (i_value - {{(dac_pkg::DAC_W-1){1'b0}}, 1'b1})
                                 : i_value;
                end
            end
            dac_pkg::S_STRIP: begin
                if (sts.done) begin
                    if (cry_nz) begin
                        // restore the value before the failed strip
                        ctl.load = 1'b1;
                    end else begin
                        n_save = sts.val;
                        n_e    = W'(r_e + dac_pkg::K_ONE);
                    end
                end
            end
            dac_pkg::S_DIGIT: begin
                if (sts.done) begin
                    n_dig = sts.cry;
                end
            end
            dac_pkg::S_SPLIT10: begin
                if (sts.done) begin
                    n_e = sts.cry;
                end
            end
            dac_pkg::S_SPLIT9: begin
                if (sts.done) begin
                    n_dig = W'(sts.cry + dac_pkg::K_ONE);
                end
            end
            dac_pkg::S_PACK9, dac_pkg::S_PACK10, dac_pkg::S_REBUILD: begin
                if (sts.done) begin
                    n_ovf = r_ovf | cry_nz;
                end
            end
            dac_pkg::S_SCALE: begin
                if (sts.done) begin
                    n_ovf = r_ovf | cry_nz;
                    n_e   = W'(r_e - dac_pkg::K_ONE);
                end
            end
            default: begin
                n_ovf = r_ovf;
            end
        endcase

        // Launch the next pass in the cycle after a request is taken or a pass ends
        n_go = (n_state != dac_pkg::S_IDLE) && (n_state != dac_pkg::S_OUT)
            && (acc || sts.done);
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= dac_pkg::S_IDLE;
            r_go     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_go    <= n_go;
            if ((r_state == dac_pkg::S_OUT) && out_free) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Working and result registers
    always_ff @(posedge i_clk) begin
        r_e    <= n_e;
        r_dig  <= n_dig;
        r_save <= n_save;
        r_ovf  <= n_ovf;
        if ((r_state == dac_pkg::S_OUT) && out_free) begin
            r_res  <= sts.val;
            r_oovf <= r_ovf;
        end
    end

    assign o_stall    = (r_state != dac_pkg::S_IDLE);
    assign o_valid    = r_ovalid;
    assign o_result   = r_res;
    assign o_overflow = r_oovf;

endmodule

// ----- rtl/dac_slice.sv -----
module dac_slice (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_load,
    input  logic [dac_pkg::NIB_W-1:0] i_load_nib,
    input  logic                      i_div,
    input  logic [dac_pkg::NIB_W-1:0] i_k,
    input  logic                      i_tok,
    input  logic [dac_pkg::NIB_W-1:0] i_cry,
    output logic                      o_tok,
    output logic [dac_pkg::NIB_W-1:0] o_cry,
    output logic [dac_pkg::NIB_W-1:0] o_nib
);

    logic                        r_tok;
    logic [dac_pkg::NIB_W-1:0]   r_cry;
    logic [dac_pkg::NIB_W-1:0]   r_nib;
    logic [2*dac_pkg::NIB_W-1:0] qr;
    logic [2*dac_pkg::NIB_W-1:0] prod;

    // Divide step: remainder from above is the high digit
    assign qr = dac_pkg::div_small({i_cry, r_nib}, i_k);

    // Multiply step: carry from below is added in
    assign prod = {{dac_pkg::NIB_W{1'b0}}, r_nib} * {{dac_pkg::NIB_W{1'b0}}, i_k}
                + {{dac_pkg::NIB_W{1'b0}}, i_cry};

    // Pass the wave token on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= 1'b0;
        end else begin
            r_tok <= i_tok;
        end
    end

    // Load or rewrite the digit as the wave passes
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_nib <= i_load_nib;
        end else if (i_tok) begin
            if (i_div) begin
                r_nib <= qr[2*dac_pkg::NIB_W-1:dac_pkg::NIB_W];
                r_cry <= qr[dac_pkg::NIB_W-1:0];
            end else begin
                r_nib <= prod[dac_pkg::NIB_W-1:0];
                r_cry <= prod[2*dac_pkg::NIB_W-1:dac_pkg::NIB_W];
            end
        end
    end

    assign o_tok = r_tok;
    assign o_cry = r_cry;
    assign o_nib = r_nib;

endmodule

// ----- rtl/dac_row.sv -----
module dac_row (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dac_pkg::t_row_ctl i_ctl,
    output dac_pkg::t_row_sts o_sts
);

    localparam int unsigned N = dac_pkg::N_SLICE;
    localparam int unsigned W = dac_pkg::NIB_W;

    // Slice outputs, with the two row ends tacked on
    logic [N+1:0]  tok_x;
    logic [W-1:0]  cry_x [N+2];
    logic [N-1:0]  tok;
    logic [W-1:0]  cry   [N];
    logic [W-1:0]  nib   [N];
    logic [dac_pkg::DAC_W-1:0] val;

    // Multiply waves enter at the bottom, divide waves at the top
    assign tok_x[0]   = i_ctl.start;
    assign tok_x[N+1] = i_ctl.start;
    assign cry_x[0]   = i_ctl.cin;
    assign cry_x[N+1] = '0;

    for (genvar g = 0; g < N; g++) begin : g_slice
        logic         tok_in;
        logic [W-1:0] cry_in;

        assign tok_x[g+1] = tok[g];
        assign cry_x[g+1] = cry[g];

        // Take the neighbor in the direction of the wave
        assign tok_in = i_ctl.div ? tok_x[g+2] : tok_x[g];
        assign cry_in = i_ctl.div ? cry_x[g+2] : cry_x[g];

        dac_slice u_slice (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_load     (i_ctl.load),
            .i_load_nib (i_ctl.load_val[g*W +: W]),
            .i_div      (i_ctl.div),
            .i_k        (i_ctl.k),
            .i_tok      (tok_in),
            .i_cry      (cry_in),
            .o_tok      (tok[g]),
            .o_cry      (cry[g]),
            .o_nib      (nib[g])
        );

        assign val[g*W +: W] = nib[g];
    end

    // Report the end of the wave and what falls out of the row
    assign o_sts.val  = val;
    assign o_sts.done = i_ctl.div ? tok[0] : tok[N-1];
    assign o_sts.cry  = i_ctl.div ? cry[0] : cry[N-1];

endmodule

// ----- rtl/dac_checker.sv -----
module dac_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_valid,
    input logic                      o_stall,
    input logic                      i_command,
    input logic [dac_pkg::DAC_W-1:0] i_value,
    input logic                      o_valid,
    input logic                      i_stall,
    input logic [dac_pkg::DAC_W-1:0] o_result,
    input logic                      o_overflow
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_result) && $stable(o_overflow))
        else $error("result changed while stalled");

    // Accepted request makes the block busy
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("block not busy after a request");

    // Busy ends only by posting a result
    a_done_posts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $fell(o_stall) |-> o_valid)
        else $error("request finished without a result");

    // A fresh result appears only as the request finishes
    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && o_valid && !($past(o_valid) && $past(i_stall))
        |-> $fell(o_stall))
        else $error("result without a finished request");

endmodule

bind decimal_amount_compressor dac_checker u_dac_checker (.*);

// ----- bench/decimal_amount_compressor_tb.sv -----
module decimal_amount_compressor_tb;

    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned SETTLE_CYCLES  = 200;
    localparam int unsigned RANDOM_ITEMS   = 1110;
    localparam int unsigned STEADY_ITEMS   = 100;
    localparam int unsigned HOLD_CYCLES    = 500;

    localparam logic CMD_COMPRESS   = 1'b0;
    localparam logic CMD_DECOMPRESS = 1'b1;

    typedef logic [dac_pkg::DAC_W-1:0] t_word;

    localparam t_word ONE  = t_word'(dac_pkg::K_ONE);
    localparam t_word NINE = t_word'(dac_pkg::K_NINE);
    localparam t_word TEN  = t_word'(dac_pkg::K_TEN);

    typedef struct packed {
        t_word result;
        logic  overflow;
    } t_conversion;

    logic  i_clk;
    logic  i_rst_n;
    logic  i_valid;
    logic  o_stall;
    logic  i_command;
    t_word i_value;
    logic  o_valid;
    logic  i_stall;
    t_word o_result;
    logic  o_overflow;

    t_conversion pending_conversions[$];
    t_conversion oldest_conversion;
    int unsigned error_count     = 0;
    int unsigned quiet_cycles    = 0;
    bit          sender_jitter   = 1'b0;
    bit          receiver_jitter = 1'b0;
    int unsigned receiver_hold   = 0;

    decimal_amount_compressor dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_command  (i_command),
        .i_value    (i_value),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_result   (o_result),
        .o_overflow (o_overflow)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Multiply; the top bit flags a product wider than the word
    function automatic logic [dac_pkg::DAC_W:0] mul_wide(input t_word a, input t_word k);
        logic [2*dac_pkg::DAC_W-1:0] prod;
        prod = {{dac_pkg::DAC_W{1'b0}}, a} * {{dac_pkg::DAC_W{1'b0}}, k};
        return {(prod[2*dac_pkg::DAC_W-1:dac_pkg::DAC_W] != '0), prod[dac_pkg::DAC_W-1:0]};
    endfunction

    // Add; the top bit is the carry out of the word
    function automatic logic [dac_pkg::DAC_W:0] add_wide(input t_word a, input t_word b);
        return {1'b0, a} + {1'b0, b};
    endfunction

    function automatic t_word pow10(input int unsigned e);
        t_word p;
        p = ONE;
        for (int unsigned j = 0; j < e; j++) p = p * TEN;
        return p;
    endfunction

    // Amount to code: strip trailing zeros, then fold digit and exponent in
    function automatic t_conversion compress_amount(input t_word amount);
        t_conversion             conv;
        t_word                   v;
        t_word                   digit;
        logic [dac_pkg::DAC_W:0] step;
        int unsigned             zeros;
        conv  = '0;
        v     = amount;
        zeros = 0;
        if (amount != '0) begin
            while ((v % TEN) == '0 && zeros < dac_pkg::EXP_MAX) begin
                v = v / TEN;
                zeros++;
            end
            if (zeros < dac_pkg::EXP_MAX) begin
                digit = v % TEN;
                v     = v / TEN;
                step  = mul_wide(v, NINE);
                conv.overflow |= step[dac_pkg::DAC_W];
                step  = add_wide(step[dac_pkg::DAC_W-1:0], digit - ONE);
                conv.overflow |= step[dac_pkg::DAC_W];
                step  = mul_wide(step[dac_pkg::DAC_W-1:0], TEN);
                conv.overflow |= step[dac_pkg::DAC_W];
                step  = add_wide(step[dac_pkg::DAC_W-1:0], t_word'(zeros + 1));
                conv.overflow |= step[dac_pkg::DAC_W];
            end else begin
                step  = mul_wide(v - ONE, TEN);
                conv.overflow |= step[dac_pkg::DAC_W];
                step  = add_wide(step[dac_pkg::DAC_W-1:0], TEN);
                conv.overflow |= step[dac_pkg::DAC_W];
            end
            conv.result = step[dac_pkg::DAC_W-1:0];
        end
        return conv;
    endfunction

    // Code to amount: split exponent and digit, then scale by ten
    function automatic t_conversion decompress_code(input t_word code);
        t_conversion             conv;
        t_word                   x;
        t_word                   digit;
        t_word                   n;
        logic [dac_pkg::DAC_W:0] step;
        int unsigned             zeros;
        conv = '0;
        if (code != '0) begin
            x     = code - ONE;
            zeros = int'(x % TEN);
            x     = x / TEN;
            if (zeros < dac_pkg::EXP_MAX) begin
                digit = (x % NINE) + ONE;
                x     = x / NINE;
                n     = x * TEN + digit;
            end else begin
                n = x + ONE;
            end
            for (int unsigned j = 0; j < zeros; j++) begin
                step = mul_wide(n, TEN);
                conv.overflow |= step[dac_pkg::DAC_W];
                n = step[dac_pkg::DAC_W-1:0];
            end
            conv.result = n;
        end
        return conv;
    endfunction

    function automatic t_conversion convert_request(input logic cmd, input t_word value);
        return (cmd == CMD_COMPRESS) ? compress_amount(value) : decompress_code(value);
    endfunction

    // Offer one request, hold it until accepted, then maybe go idle
    task automatic send_request(input logic cmd, input t_word value);
        i_valid   <= 1'b1;
        i_command <= cmd;
        i_value   <= value;
        do @(posedge i_clk); while (o_stall);
        pending_conversions = {pending_conversions, convert_request(cmd, value)};
        if (sender_jitter && $urandom_range(0, 2) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    // Drop valid and hold until every expected result is in
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_conversions.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_random_items(input int unsigned count);
        int unsigned pick;
        logic        cmd;
        t_word       value;
        t_word       noise;
        t_conversion conv;
        for (int unsigned i = 0; i < count; i++) begin
            pick  = $urandom_range(0, 9);
            noise = {$urandom, $urandom};
            cmd   = CMD_COMPRESS;
            case (pick)
                0, 1: begin
                    value = noise;
                end
                2, 3: begin
                    // round amounts: short mantissa times a power of ten
                    value = (noise >> $urandom_range(0, 60)) * pow10($urandom_range(0, 12));
                end
                4, 5: begin
                    cmd   = CMD_DECOMPRESS;
                    value = noise;
                end
                6, 7: begin
                    // well-formed codes taken from real amounts
                    cmd   = CMD_DECOMPRESS;
                    conv  = compress_amount(noise >> $urandom_range(0, 63));
                    value = conv.result;
                end
                8: begin
                    cmd   = logic'($urandom_range(0, 1));
                    value = t_word'($urandom_range(0, 1000));
                end
                default: begin
                    cmd   = logic'($urandom_range(0, 1));
                    value = ~t_word'($urandom_range(0, 1000));
                end
            endcase
            send_request(cmd, value);
        end
    endtask

    task automatic test_zero_inputs();
        send_request(CMD_COMPRESS, '0);
        send_request(CMD_DECOMPRESS, '0);
        wait_drained();
    endtask

    task automatic test_compress_corners();
        send_request(CMD_COMPRESS, ONE);
        send_request(CMD_COMPRESS, NINE);
        send_request(CMD_COMPRESS, TEN);
        send_request(CMD_COMPRESS, 64'd123456789);
        send_request(CMD_COMPRESS, 64'd2100000000);
        send_request(CMD_COMPRESS, 5 * pow10(8));
        send_request(CMD_COMPRESS, pow10(9));
        send_request(CMD_COMPRESS, 7 * pow10(12));
        send_request(CMD_COMPRESS, 64'd18446744000000000000);
        send_request(CMD_COMPRESS, 64'd999999999999999999);
        send_request(CMD_COMPRESS, '1);
        wait_drained();
    endtask

    task automatic test_decompress_corners();
        send_request(CMD_DECOMPRESS, ONE);
        send_request(CMD_DECOMPRESS, TEN);
        send_request(CMD_DECOMPRESS, 64'd11);
        send_request(CMD_DECOMPRESS, 64'd90);
        send_request(CMD_DECOMPRESS, 64'd1844674407370955160);
        send_request(CMD_DECOMPRESS, 64'd18446744073709551609);
        send_request(CMD_DECOMPRESS, '1);
        wait_drained();
    endtask

    // Hold the output off for a long stretch while requests keep coming
    task automatic test_output_hold_off();
        receiver_jitter = 1'b0;
        sender_jitter   = 1'b0;
        receiver_hold   = HOLD_CYCLES;
        for (int unsigned i = 0; i < 8; i++) begin
            send_request(logic'($urandom_range(0, 1)),
                         (i < 4) ? t_word'(0) : t_word'($urandom_range(1, 99)));
        end
        wait_drained();
    endtask

    // Pause the sender until the block has emptied, then resume
    task automatic test_sender_pause();
        sender_jitter   = 1'b1;
        receiver_jitter = 1'b1;
        send_random_items(6);
        wait_drained();
        send_random_items(6);
        wait_drained();
    endtask

    task automatic test_random_mix();
        sender_jitter   = 1'b1;
        receiver_jitter = 1'b1;
        send_random_items(RANDOM_ITEMS);
        wait_drained();
    endtask

    task automatic test_steady_stream();
        sender_jitter   = 1'b0;
        receiver_jitter = 1'b0;
        send_random_items(STEADY_ITEMS);
        wait_drained();
    endtask

    // Receiver: long hold on request, else random stall bursts
    initial begin
        i_stall <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (receiver_hold != 0) begin
                i_stall <= 1'b1;
                repeat (receiver_hold) @(posedge i_clk);
                receiver_hold = 0;
                i_stall <= 1'b0;
            end else if (receiver_jitter && $urandom_range(0, 3) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_conversions.size() == 0) begin
                $error("unexpected result: result %0d, overflow %0d", o_result, o_overflow);
                error_count++;
            end else begin
                oldest_conversion = pending_conversions.pop_front();
                if (o_result !== oldest_conversion.result) begin
                    $error("result mismatch: expected %0d, actual %0d",
                           oldest_conversion.result, o_result);
                    error_count++;
                end
                if (o_overflow !== oldest_conversion.overflow) begin
                    $error("overflow mismatch: expected %0d, actual %0d",
                           oldest_conversion.overflow, o_overflow);
                    error_count++;
                end
            end
        end
    end

    // Stop the run when no handshake happens for too long
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("decimal_amount_compressor_tb failed");
            $finish;
        end
    end

    initial begin
        i_rst_n   <= 1'b0;
        i_valid   <= 1'b0;
        i_command <= CMD_COMPRESS;
        i_value   <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_zero_inputs();
        test_compress_corners();
        test_decompress_corners();
        test_output_hold_off();
        test_sender_pause();
        test_random_mix();
        test_steady_stream();

        // let any stray result show up before the verdict
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0 && pending_conversions.size() == 0) begin
            $display("decimal_amount_compressor_tb passed");
        end else begin
            $display("decimal_amount_compressor_tb failed");
        end
        $finish;
    end

endmodule
